[rtl/fdtd_pkg.sv]
package fdtd_pkg;

   localparam int FIELD_W    = 16;
   localparam int TIME_W     = 16;
   localparam int CELL_W     = 8;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_PULSE_CENTER = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_INV_SPREAD   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SOURCE_CELL  = 2'd2;

   localparam logic [TIME_W-1:0] PULSE_CENTER_RST = 16'd40;
   localparam logic [15:0]       INV_SPREAD_RST   = 16'd5461;
   localparam logic [CELL_W-1:0] SOURCE_CELL_RST  = 8'd128;
   localparam logic [TIME_W-1:0] TIME_MAX         = '1;

   localparam logic [63:0] Q32_EXP_M1 = 64'd1580030169;

   typedef enum logic [0:0] {
      REQ_STEP = 1'b0,
      REQ_READ = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PULSE,
      ST_ESWEEP,
      ST_HSWEEP,
      ST_RDADDR,
      ST_RDDATA,
      ST_DONE
   } core_state_type;

   typedef struct packed {
      req_kind_type      kind;
      logic [CELL_W-1:0] cell_idx;
   } req_cmd_type;

   typedef struct packed {
      logic                      done;
      logic signed [FIELD_W-1:0] e;
      logic signed [FIELD_W-1:0] h;
      logic [TIME_W-1:0]         time_now;
   } core_rsp_type;

   // old + floor((a - b) / 2), saturated to 16 bits
   function automatic logic signed [FIELD_W-1:0] field_update(
      input logic signed [FIELD_W-1:0] old,
      input logic signed [FIELD_W-1:0] a,
      input logic signed [FIELD_W-1:0] b
   );
      logic signed [FIELD_W:0]   diff;
      logic signed [FIELD_W:0]   half;
      logic signed [FIELD_W+1:0] sum;
      diff = $signed({a[FIELD_W-1], a}) - $signed({b[FIELD_W-1], b});
      half = diff >>> 1;
      sum  = $signed({{2{old[FIELD_W-1]}}, old}) + $signed({half[FIELD_W], half});
      if (sum > 18'sd32767) begin
         return 16'sh7FFF;
      end else if (sum < -18'sd32768) begin
         return 16'sh8000;
      end
      return sum[FIELD_W-1:0];
   endfunction

   // round(16384 * exp(-y)), y in Q32
   function automatic logic [15:0] pulse_q14(input logic [63:0] y);
      logic [63:0] whole;
      logic [63:0] frac;
      logic [63:0] term;
      logic [63:0] r;
      longint      sum;
      whole = y >> 32;
      frac  = {32'd0, y[31:0]};
      term  = 64'd1 << 32;
      sum   = longint'(term);
      term = ((term * frac) >> 32) / 64'd1;  sum = sum - longint'(term);
      term = ((term * frac) >> 32) / 64'd2;  sum = sum + longint'(term);
      term = ((term * frac) >> 32) / 64'd3;  sum = sum - longint'(term);
      term = ((term * frac) >> 32) / 64'd4;  sum = sum + longint'(term);
      term = ((term * frac) >> 32) / 64'd5;  sum = sum - longint'(term);
      term = ((term * frac) >> 32) / 64'd6;  sum = sum + longint'(term);
      term = ((term * frac) >> 32) / 64'd7;  sum = sum - longint'(term);
      term = ((term * frac) >> 32) / 64'd8;  sum = sum + longint'(term);
      term = ((term * frac) >> 32) / 64'd9;  sum = sum - longint'(term);
      term = ((term * frac) >> 32) / 64'd10; sum = sum + longint'(term);
      term = ((term * frac) >> 32) / 64'd11; sum = sum - longint'(term);
      term = ((term * frac) >> 32) / 64'd12; sum = sum + longint'(term);
      term = ((term * frac) >> 32) / 64'd13; sum = sum - longint'(term);
      term = ((term * frac) >> 32) / 64'd14; sum = sum + longint'(term);
      term = ((term * frac) >> 32) / 64'd15; sum = sum - longint'(term);
      term = ((term * frac) >> 32) / 64'd16; sum = sum + longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      r = 64'(sum);
      if (r > 64'hFFFF_FFFF) begin
         r = 64'hFFFF_FFFF;
      end
      for (int k = 0; k < 32; k++) begin
         if (64'(k) < whole) begin
            r = (r * Q32_EXP_M1) >> 32;
         end
      end
      r = (r * 64'd16384 + (64'd1 << 31)) >> 32;
      return r[15:0];
   endfunction

endpackage

[rtl/fdtd_ram.sv]
module fdtd_ram
   import fdtd_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/fdtd_pulse.sv]
module fdtd_pulse
   import fdtd_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic                      clock,
   input  logic [TIME_W-1:0]         pulse_center,
   input  logic [15:0]               inv_spread,
   input  logic [TIME_W-1:0]         time_now,
   output logic signed [FIELD_W-1:0] pulse_value
);

   localparam int          IW = $clog2(DEPTH);
   localparam int          DW = $clog2(DEPTH + 1);
   localparam int          PW = 32 + DW;
   localparam logic [63:0] D2 = 64'(DEPTH) * 64'(DEPTH);

   logic [15:0] rom [DEPTH];

   for (genvar g = 0; g < DEPTH; g++) begin : g_rom
      localparam logic [63:0] Y = ((64'd32 * 64'(g) * 64'(g)) << 32) / D2;
      assign rom[g] = pulse_q14(Y);
   end

   logic [TIME_W-1:0] dist_ff, dist_in;
   logic [31:0]       x_ff, x_in;
   logic [PW-1:0]     prod;
   logic [PW-20:0]    idx_full;
   logic [IW-1:0]     idx_ff, idx_in;
   logic              oor_ff, oor_in;
   logic [15:0]       value_ff, value_in;

   always_comb begin
      dist_in  = (pulse_center >= time_now) ? (pulse_center - time_now)
                                            : (time_now - pulse_center);
      x_in     = 32'(dist_ff) * 32'(inv_spread);
      prod     = PW'(x_ff) * PW'(DEPTH);
      idx_full = prod[PW-1:19];
      oor_in   = idx_full >= (PW-19)'(DEPTH);
      idx_in   = idx_full[IW-1:0];
      value_in = oor_ff ? 16'd0 : rom[idx_ff];
   end

   always_ff @(posedge clock) begin
      dist_ff  <= dist_in;
      x_ff     <= x_in;
      idx_ff   <= idx_in;
      oor_ff   <= oor_in;
      value_ff <= value_in;
   end

   assign pulse_value = $signed(value_ff);

endmodule

[rtl/fdtd_core.sv]
module fdtd_core
   import fdtd_pkg::*;
#(
   parameter int CELLS = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_go,
   input  req_cmd_type               req_cmd,
   output logic                      idle,
   input  logic [CELL_W-1:0]         source_cell,
   input  logic signed [FIELD_W-1:0] pulse_value,
   output logic [TIME_W-1:0]         time_now,
   input  logic                      res_taken,
   output core_rsp_type              res
);

   localparam int               AW        = $clog2(CELLS);
   localparam int               CW        = AW + 1;
   localparam logic [CW-1:0]    CNT_END   = CW'(CELLS);
   localparam logic [AW-1:0]    ADDR_LAST = AW'(CELLS - 1);
   localparam logic [1:0]       WAIT_LAST = 2'd3;

   core_state_type            state_ff, state_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [1:0]                wait_ff, wait_in;
   logic [CELL_W-1:0]         cell_ff, cell_in;
   logic [TIME_W-1:0]         time_ff, time_in;
   logic                      rd_vld_ff, rd_vld_in;
   logic [AW-1:0]             rd_addr_ff, rd_addr_in;
   logic signed [FIELD_W-1:0] hprev_ff, hprev_in;
   logic signed [FIELD_W-1:0] eprev_ff, eprev_in;
   logic signed [FIELD_W-1:0] res_e_ff, res_e_in;
   logic signed [FIELD_W-1:0] res_h_ff, res_h_in;

   logic [AW-1:0]             rd_addr;
   logic                      e_we, h_we;
   logic [AW-1:0]             e_waddr, h_waddr;
   logic signed [FIELD_W-1:0] e_wdata, h_wdata;
   logic [FIELD_W-1:0]        e_q_raw, h_q_raw;
   logic signed [FIELD_W-1:0] e_q, h_q;
   logic                      src_ok, src_hit, cell_ok;

   fdtd_ram #(.DEPTH(CELLS), .WIDTH(FIELD_W)) u_e_ram (
      .clock (clock),
      .we    (e_we),
      .waddr (e_waddr),
      .wdata (e_wdata),
      .raddr (rd_addr),
      .rdata (e_q_raw)
   );

   fdtd_ram #(.DEPTH(CELLS), .WIDTH(FIELD_W)) u_h_ram (
      .clock (clock),
      .we    (h_we),
      .waddr (h_waddr),
      .wdata (h_wdata),
      .raddr (rd_addr),
      .rdata (h_q_raw)
   );

   assign e_q = $signed(e_q_raw);
   assign h_q = $signed(h_q_raw);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         cnt_ff    <= '0;
         wait_ff   <= '0;
         time_ff   <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         wait_ff   <= wait_in;
         time_ff   <= time_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff    <= cell_in;
      rd_addr_ff <= rd_addr_in;
      hprev_ff   <= hprev_in;
      eprev_ff   <= eprev_in;
      res_e_ff   <= res_e_in;
      res_h_ff   <= res_h_in;
   end

   always_comb begin
      src_ok  = int'(source_cell) < CELLS;
      src_hit = src_ok && (rd_addr_ff == AW'(source_cell));
      cell_ok = int'(cell_ff) < CELLS;

      state_in   = state_ff;
      cnt_in     = cnt_ff;
      wait_in    = wait_ff;
      cell_in    = cell_ff;
      time_in    = time_ff;
      rd_vld_in  = 1'b0;
      rd_addr_in = rd_addr_ff;
      hprev_in   = hprev_ff;
      eprev_in   = eprev_ff;
      res_e_in   = res_e_ff;
      res_h_in   = res_h_ff;
      rd_addr    = cnt_ff[AW-1:0];
      e_we       = 1'b0;
      h_we       = 1'b0;
      e_waddr    = rd_addr_ff;
      h_waddr    = rd_addr_ff - AW'(1);
      e_wdata    = field_update(e_q, hprev_ff, h_q);
      h_wdata    = field_update(hprev_ff, eprev_ff, e_q);
      idle       = 1'b0;
      res.done   = 1'b0;

      if (src_hit) begin
         e_wdata = pulse_value;
      end else if (rd_addr_ff == '0) begin
         e_wdata = e_q;
      end

      case (state_ff)
         ST_CLEAR: begin
            e_we    = 1'b1;
            h_we    = 1'b1;
            e_waddr = cnt_ff[AW-1:0];
            h_waddr = cnt_ff[AW-1:0];
            e_wdata = '0;
            h_wdata = '0;
            cnt_in  = cnt_ff + CW'(1);
            if (cnt_ff[AW-1:0] == ADDR_LAST) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            idle = 1'b1;
            if (req_go) begin
               if (req_cmd.kind == REQ_STEP) begin
                  cell_in  = source_cell;
                  wait_in  = '0;
                  state_in = ST_PULSE;
                  if (time_ff != TIME_MAX) begin
                     time_in = time_ff + TIME_W'(1);
                  end
               end else begin
                  cell_in  = req_cmd.cell_idx;
                  state_in = ST_RDADDR;
               end
            end
         end
         ST_PULSE: begin
            wait_in = wait_ff + 2'd1;
            if (wait_ff == WAIT_LAST) begin
               cnt_in   = '0;
               state_in = ST_ESWEEP;
            end
         end
         ST_ESWEEP: begin
            if (cnt_ff != CNT_END) begin
               rd_vld_in  = 1'b1;
               rd_addr_in = cnt_ff[AW-1:0];
               cnt_in     = cnt_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               e_we     = 1'b1;
               hprev_in = h_q;
               if (rd_addr_ff == ADDR_LAST) begin
                  cnt_in   = '0;
                  state_in = ST_HSWEEP;
               end
            end
         end
         ST_HSWEEP: begin
            if (cnt_ff != CNT_END) begin
               rd_vld_in  = 1'b1;
               rd_addr_in = cnt_ff[AW-1:0];
               cnt_in     = cnt_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               hprev_in = h_q;
               eprev_in = e_q;
               h_we     = rd_addr_ff != '0;
               if (rd_addr_ff == ADDR_LAST) begin
                  state_in = ST_RDADDR;
               end
            end
         end
         ST_RDADDR: begin
            rd_addr  = AW'(cell_ff);
            state_in = ST_RDDATA;
         end
         ST_RDDATA: begin
            res_e_in = cell_ok ? e_q : '0;
            res_h_in = cell_ok ? h_q : '0;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            res.done = 1'b1;
            if (res_taken) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      res.e        = res_e_ff;
      res.h        = res_h_ff;
      res.time_now = time_ff;
   end

   assign time_now = time_ff;

   a_time_only_on_step: assert property (@(posedge clock) disable iff (reset)
      !(req_go && idle && req_cmd.kind == REQ_STEP) |=> $stable(time_ff))
      else $error("time count moved without a step");

   a_time_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> time_ff >= $past(time_ff))
      else $error("time count went backward");

   a_esweep_after_pulse: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ESWEEP && $past(state_ff) != ST_ESWEEP) |->
         $past(state_ff) == ST_PULSE)
      else $error("E sweep entered before pulse was ready");

   a_idle_no_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !rd_vld_ff)
      else $error("sweep read still in flight while idle");

   a_h_first_kept: assert property (@(posedge clock) disable iff (reset)
      (h_we && state_ff == ST_HSWEEP) |-> rd_addr_ff != '0)
      else $error("H write without its right neighbor");

endmodule

[rtl/fdtd_1d_field_update_unit.sv]
// 1-D free-space FDTD engine with Q1.14 E and H fields held in two synchronous
// field memories of CELLS words. A step word (req_tuser = 0) advances time,
// sweeps the E memory once and the H memory once, injects the Gaussian pulse at
// source_cell and returns that cell's fields; a read word (req_tuser = 1)
// returns the cell in req_tdata. Each sweep walks its memory one cell a cycle
// through the one read port per memory. One word is in work at a time; a
// finished word waits in the output register while the next is accepted.
// After reset the memories are cleared in a pass over all CELLS words with
// req_tready low. CSR writes are taken on any cycle but must only be issued
// while idle.
module fdtd_1d_field_update_unit
   import fdtd_pkg::*;
#(
   parameter int CELLS             = 256,
   parameter int PULSE_TABLE_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] cell_index
   input  logic [0:0]            req_tuser,   // [0] req_type

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [47:0]           rsp_tdata,   // [15:0] e_value, [31:16] h_value,
                                              // [47:32] time_now

   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [TIME_W-1:0]         pulse_center_ff;
   logic [15:0]               inv_spread_ff;
   logic [CELL_W-1:0]         source_cell_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [47:0]               rsp_data_ff, rsp_data_in;

   logic                      core_idle;
   logic                      req_go;
   req_cmd_type               req_cmd;
   core_rsp_type              core_res;
   logic                      res_taken;
   logic [TIME_W-1:0]         time_now;
   logic signed [FIELD_W-1:0] pulse_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_center_ff <= PULSE_CENTER_RST;
         inv_spread_ff   <= INV_SPREAD_RST;
         source_cell_ff  <= SOURCE_CELL_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_PULSE_CENTER: pulse_center_ff <= csr_wdata[TIME_W-1:0];
            CSR_INV_SPREAD:   inv_spread_ff   <= csr_wdata[15:0];
            CSR_SOURCE_CELL:  source_cell_ff  <= csr_wdata[CELL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   fdtd_pulse #(.DEPTH(PULSE_TABLE_DEPTH)) u_pulse (
      .clock        (clock),
      .pulse_center (pulse_center_ff),
      .inv_spread   (inv_spread_ff),
      .time_now     (time_now),
      .pulse_value  (pulse_value)
   );

   assign req_tready       = core_idle;
   assign req_go           = req_tvalid && core_idle;
   assign req_cmd.kind     = req_kind_type'(req_tuser);
   assign req_cmd.cell_idx = req_tdata;

   fdtd_core #(.CELLS(CELLS)) u_core (
      .clock       (clock),
      .reset       (reset),
      .req_go      (req_go),
      .req_cmd     (req_cmd),
      .idle        (core_idle),
      .source_cell (source_cell_ff),
      .pulse_value (pulse_value),
      .time_now    (time_now),
      .res_taken   (res_taken),
      .res         (core_res)
   );

   always_comb begin
      res_taken    = core_res.done && (!rsp_valid_ff || rsp_tready);
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (res_taken) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {core_res.time_now, core_res.h, core_res.e};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[test/tb_top.sv]
module tb_top;
   import fdtd_pkg::*;

   localparam int CELLS           = 256;
   localparam int TABLE_DEPTH     = 256;
   localparam int WATCHDOG_LIMIT  = 20000;
   localparam int SETTLE_CYCLES   = 2 * CELLS + 100;
   localparam int HOLD_OFF_CYCLES = 1500;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 104;
   localparam int STEP_PCT        = 35;

   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE = 2'd3;
   localparam logic [63:0] E_INV_Q32 = 64'd1580030169;

   typedef struct packed {
      logic signed [FIELD_W-1:0] e;
      logic signed [FIELD_W-1:0] h;
      logic [TIME_W-1:0]         t;
   } cell_fields_type;

   class yee_grid_board;
      logic signed [FIELD_W-1:0] e_cells[CELLS];
      logic signed [FIELD_W-1:0] h_cells[CELLS];
      logic [15:0]               gauss[TABLE_DEPTH];
      logic [TIME_W-1:0]         step_count;
      logic [15:0]               center;
      logic [15:0]               spread;
      logic [CELL_W-1:0]         src;
      cell_fields_type           pending_fields[$];
      int                        errors;

      function new();
         int i;
         for (i = 0; i < CELLS; i++) begin
            e_cells[i] = '0;
            h_cells[i] = '0;
         end
         for (i = 0; i < TABLE_DEPTH; i++) begin
            gauss[i] = gauss_q14(i);
         end
         step_count = '0;
         center     = 16'd40;
         spread     = 16'd5461;
         src        = 8'd128;
         errors     = 0;
      endfunction

      // round(16384 * exp(-0.5 * (8*i/depth)^2))
      function logic [15:0] gauss_q14(int unsigned i);
         logic [63:0] y;
         logic [63:0] whole;
         logic [63:0] frac;
         logic [63:0] term;
         logic [63:0] r;
         longint      acc;
         int          k;
         y     = ((64'd32 * i * i) << 32) / 64'(TABLE_DEPTH * TABLE_DEPTH);
         whole = y >> 32;
         frac  = {32'd0, y[31:0]};
         term  = 64'd1 << 32;
         acc   = longint'(term);
         for (k = 1; k <= 16; k++) begin
            term = ((term * frac) >> 32) / 64'(k);
            if (k % 2 == 1) begin
               acc = acc - longint'(term);
            end else begin
               acc = acc + longint'(term);
            end
         end
         if (acc < 0) begin
            acc = 0;
         end
         r = 64'(acc);
         if (r > 64'hFFFF_FFFF) begin
            r = 64'hFFFF_FFFF;
         end
         for (k = 0; k < whole; k++) begin
            r = (r * E_INV_Q32) >> 32;
         end
         r = (r * 64'd16384 + (64'd1 << 31)) >> 32;
         return r[15:0];
      endfunction

      function logic signed [FIELD_W-1:0] nudge(logic signed [FIELD_W-1:0] old,
                                                logic signed [FIELD_W-1:0] a,
                                                logic signed [FIELD_W-1:0] b);
         int d;
         int s;
         d = int'(a) - int'(b);
         s = int'(old) + (d >>> 1);
         if (s > 32767) begin
            s = 32767;
         end else if (s < -32768) begin
            s = -32768;
         end
         return s[FIELD_W-1:0];
      endfunction

      function logic signed [FIELD_W-1:0] source_pulse();
         logic [63:0] span;
         logic [63:0] idx;
         if (center >= step_count) begin
            span = 64'(center) - 64'(step_count);
         end else begin
            span = 64'(step_count) - 64'(center);
         end
         idx = (span * 64'(spread) * 64'(TABLE_DEPTH)) >> 19;
         if (idx >= TABLE_DEPTH) begin
            return '0;
         end
         return gauss[idx];
      endfunction

      function void advance();
         int k;
         if (step_count != TIME_MAX) begin
            step_count++;
         end
         for (k = 1; k < CELLS; k++) begin
            e_cells[k] = nudge(e_cells[k], h_cells[k-1], h_cells[k]);
         end
         e_cells[src] = source_pulse();
         for (k = 0; k < CELLS - 1; k++) begin
            h_cells[k] = nudge(h_cells[k], e_cells[k], e_cells[k+1]);
         end
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
         case (addr)
            CSR_PULSE_CENTER: center = data;
            CSR_INV_SPREAD:   spread = data;
            CSR_SOURCE_CELL:  src    = data[CELL_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(req_kind_type kind, logic [CELL_W-1:0] cell_sel);
         cell_fields_type   want;
         logic [CELL_W-1:0] at;
         at = cell_sel;
         if (kind == REQ_STEP) begin
            advance();
            at = src;
         end
         want.e = e_cells[at];
         want.h = h_cells[at];
         want.t = step_count;
         pending_fields.push_back(want);
      endfunction

      function int pending();
         return pending_fields.size();
      endfunction

      task report(string what, int got, int want);
         $display("mismatch %0s: got %0d expected %0d", what, got, want);
         errors++;
      endtask

      task check_result(logic [47:0] word);
         cell_fields_type           want;
         logic signed [FIELD_W-1:0] e;
         logic signed [FIELD_W-1:0] h;
         logic [TIME_W-1:0]         t;
         e = word[15:0];
         h = word[31:16];
         t = word[47:32];
         if (pending_fields.size() == 0) begin
            report("unexpected word e_value", e, 0);
            return;
         end
         want = pending_fields.pop_front();
         if (e !== want.e) report("e_value", e, want.e);
         if (h !== want.h) report("h_value", h, want.h);
         if (t !== want.t) report("time_now", t, want.t);
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;
   logic [0:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [47:0]           rsp_tdata;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   yee_grid_board sb;
   int            hold_cycles = 0;
   bit            calm = 0;
   int            idle_cycles = 0;

   fdtd_1d_field_update_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side: check each word, stall in bursts, hold off long on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata);
         end
         if (stall_left > 0) begin
            stall_left--;
         end else if (hold_cycles > 0) begin
            stall_left  = hold_cycles;
            hold_cycles = 0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8);
         end
         rsp_tready <= (stall_left == 0);
      end
   end

   task send_word(req_kind_type kind, logic [CELL_W-1:0] cell_sel);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= cell_sel;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(kind, cell_sel);
   endtask

   task wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(addr, data);
   endtask

   task set_config(logic [15:0] center_v, logic [15:0] spread_v, logic [15:0] source_v);
      wait_idle();
      write_reg(CSR_PULSE_CENTER, center_v);
      write_reg(CSR_INV_SPREAD, spread_v);
      write_reg(CSR_SOURCE_CELL, source_v);
      write_reg(CSR_SPARE, 16'($urandom));
      csr_we <= 1'b0;
   endtask

   task run_phase(int p);
      logic [15:0]       center_v;
      logic [15:0]       spread_v;
      logic [15:0]       source_v;
      logic [CELL_W-1:0] cell_sel;
      int                i;
      case (p)
         0: begin
            center_v = 16'($urandom_range(0, 400));
            spread_v = 16'($urandom_range(1, 8000));
            source_v = 16'($urandom_range(0, 255));
         end
         1: begin
            center_v = 16'd0;
            spread_v = 16'd1;
            source_v = 16'd0;
         end
         2: begin
            center_v = 16'hFFFF;
            spread_v = 16'hFFFF;
            source_v = 16'h00FF;
         end
         3, 6: begin
            center_v = 16'($urandom_range(0, 400));
            spread_v = 16'd0;
            source_v = 16'($urandom_range(0, 255));
         end
         4: begin
            center_v = 16'($urandom);
            spread_v = 16'($urandom);
            source_v = 16'($urandom);
         end
         5: begin
            center_v = 16'($urandom_range(0, 500));
            spread_v = 16'($urandom_range(1000, 20000));
            source_v = 16'($urandom);
         end
         default: begin
            center_v = 16'($urandom_range(0, 400));
            spread_v = INV_SPREAD_RST;
            source_v = 16'($urandom_range(0, 255));
         end
      endcase
      set_config(center_v, spread_v, source_v);
      if (p == 1) hold_cycles = HOLD_OFF_CYCLES;
      if (p == PHASES - 1) calm = 1'b1;
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
         if ($urandom_range(0, 99) < STEP_PCT) begin
            send_word(REQ_STEP, 8'($urandom));
         end else begin
            if ($urandom_range(0, 1) == 0) begin
               cell_sel = sb.src + 8'($urandom_range(0, 40)) - 8'd20;
            end else begin
               cell_sel = 8'($urandom);
            end
            send_word(REQ_READ, cell_sel);
         end
      end
   endtask

   initial begin
      int p;
      sb = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= REQ_STEP;
      csr_we     <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_word(REQ_READ, 8'd0);
      send_word(REQ_READ, 8'd255);
      send_word(REQ_STEP, 8'd0);
      send_word(REQ_STEP, 8'd255);
      send_word(REQ_READ, 8'd128);
      send_word(REQ_READ, 8'd127);
      send_word(REQ_READ, 8'd129);

      // zero spread, source at the first cell, upper bits of source dropped
      set_config(16'd0, 16'd0, 16'hFF00);
      send_word(REQ_STEP, 8'hAA);
      send_word(REQ_STEP, 8'h55);
      send_word(REQ_STEP, 8'd0);
      send_word(REQ_READ, 8'd0);
      send_word(REQ_READ, 8'd1);

      // far pulse center, widest spread, source at the last cell
      set_config(16'hFFFF, 16'hFFFF, 16'h01FF);
      send_word(REQ_STEP, 8'd0);
      send_word(REQ_STEP, 8'd0);
      send_word(REQ_STEP, 8'd0);
      send_word(REQ_READ, 8'd255);
      send_word(REQ_READ, 8'd254);

      for (p = 0; p < PHASES; p++) begin
         run_phase(p);
      end

      req_tvalid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
